// ===== design/qr_segment_bit_encoder_top_defines.svh =====
// Assertion helpers used by the checker of this block.
`ifndef QR_SEGMENT_BIT_ENCODER_TOP_DEFINES_SVH
`define QR_SEGMENT_BIT_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define QSBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define QSBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/qsbe_pkg.sv =====
package qsbe_pkg;

  typedef enum logic [1:0] {
    MODE_NUMERIC  = 2'd0,
    MODE_ALNUM    = 2'd1,
    MODE_BYTE     = 2'd2,
    MODE_BYTE_ALT = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [10:0] code_value;
    logic [3:0]  code_length;
    logic        bad_char;
    logic        last_code;
  } out_item_t;

  typedef struct packed {
    logic      emit;
    out_item_t item;
  } enc_result_t;

  localparam logic [3:0] LEN_NUM_ONE   = 4'd4;
  localparam logic [3:0] LEN_ALNUM_ONE = 4'd6;
  localparam logic [3:0] LEN_NUM_TWO   = 4'd7;
  localparam logic [3:0] LEN_BYTE      = 4'd8;
  localparam logic [3:0] LEN_NUM_THREE = 4'd10;
  localparam logic [3:0] LEN_ALNUM_TWO = 4'd11;

  // Map a character to its 45-entry alphanumeric index; bit 6 flags a miss.
  function automatic logic [6:0] alnum_lookup(input logic [7:0] c);
    logic [5:0] idx;
    logic       miss;
    idx  = 6'd0;
    miss = 1'b0;
    unique case (c) inside
      [8'h30:8'h39]: idx = 6'(c - 8'h30);
      [8'h41:8'h5A]: idx = 6'(c - 8'h37);
      8'h20:         idx = 6'd36;
      8'h24:         idx = 6'd37;
      8'h25:         idx = 6'd38;
      8'h2A:         idx = 6'd39;
      8'h2B:         idx = 6'd40;
      8'h2D:         idx = 6'd41;
      8'h2E:         idx = 6'd42;
      8'h2F:         idx = 6'd43;
      8'h3A:         idx = 6'd44;
      default:       miss = 1'b1;
    endcase
    return {miss, idx};
  endfunction

endpackage

// ===== design/qr_segment_bit_encoder_top.sv =====
// QR data segment bit encoder.
// Input channel (in_valid/in_ready/in_data): one message character per
// transaction, is_last set on the final character of the message.
// Output channel (out_valid/out_ready/out_data): one packed bit group per
// transaction, right aligned in code_value with its width in code_length.
// Config channel (cfg_valid/cfg_ready/cfg_data): mode select, to be written
// by the user only while the block is idle; the block does not check it;
// a write drops any partial group. cfg_ready is always high.
// Two register stages: an accepted character is held in the input register,
// its encoded group in the result register.
// Throughput: one character per cycle while the output does not stall;
// characters that only add to a partial group give no output transaction.
// Reset: mode returns to numeric, partial group cleared, both stages empty.
// Stall: the result register holds its group while out_ready is low; the
// input register takes one more character if empty, then in_ready drops.
module qr_segment_bit_encoder_top import qsbe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  logic        advance;
  logic        item_valid;
  in_item_t    item;
  enc_result_t result;

  assign cfg_ready = 1'b1;

  qsbe_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  qsbe_encoder u_encoder (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .fire      (item_valid && advance),
    .item      (item),
    .result    (result)
  );

  qsbe_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (item_valid),
    .result    (result),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== design/qsbe_in_stage.sv =====
module qsbe_in_stage import qsbe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     advance,
  output logic     item_valid,
  output in_item_t item
);

  // Refill when empty or when the held transaction moves on this cycle.
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

endmodule

// ===== design/qsbe_encoder.sv =====
module qsbe_encoder import qsbe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_data,
  input  logic        fire,
  input  in_item_t    item,
  output enc_result_t result
);

  mode_t      mode;
  logic [6:0] pending_value;
  logic [1:0] pending_count;
  logic       pending_bad;

  logic [6:0] pending_value_next;
  logic [1:0] pending_count_next;
  logic       pending_bad_next;

  logic [3:0]  digit;
  logic        digit_bad;
  logic [9:0]  num_sum;
  logic [1:0]  count_inc;
  logic [6:0]  alnum_hit;
  logic [10:0] pair;

  always_comb begin
    digit_bad = !((item.char_code >= 8'h30) && (item.char_code <= 8'h39));
    digit     = digit_bad ? 4'd0 : 4'(item.char_code - 8'h30);
    num_sum   = 10'(pending_value) * 10'd10 + 10'(digit);
    count_inc = pending_count + 2'd1;
    alnum_hit = alnum_lookup(item.char_code);
    pair      = 11'(pending_value) * 11'd45 + 11'(alnum_hit[5:0]);
  end

  always_comb begin
    result             = '0;
    result.item.last_code = item.is_last;
    pending_value_next = '0;
    pending_count_next = '0;
    pending_bad_next   = 1'b0;
    unique case (mode) inside
      MODE_NUMERIC: begin
        if (count_inc == 2'd3 || item.is_last) begin
          result.emit            = 1'b1;
          result.item.code_value = 11'(num_sum);
          result.item.bad_char   = digit_bad || pending_bad;
          if (count_inc == 2'd3) begin
            result.item.code_length = LEN_NUM_THREE;
          end else if (count_inc == 2'd2) begin
            result.item.code_length = LEN_NUM_TWO;
          end else begin
            result.item.code_length = LEN_NUM_ONE;
          end
        end else begin
          pending_value_next = num_sum[6:0];
          pending_count_next = count_inc;
          pending_bad_next   = digit_bad || pending_bad;
        end
      end
      MODE_ALNUM: begin
        if (pending_count != 2'd0) begin
          result.emit             = 1'b1;
          result.item.code_value  = pair;
          result.item.code_length = LEN_ALNUM_TWO;
          result.item.bad_char    = alnum_hit[6] || pending_bad;
        end else if (item.is_last) begin
          result.emit             = 1'b1;
          result.item.code_value  = 11'(alnum_hit[5:0]);
          result.item.code_length = LEN_ALNUM_ONE;
          result.item.bad_char    = alnum_hit[6];
        end else begin
          pending_value_next = 7'(alnum_hit[5:0]);
          pending_count_next = 2'd1;
          pending_bad_next   = alnum_hit[6];
        end
      end
      MODE_BYTE, MODE_BYTE_ALT: begin
        result.emit             = 1'b1;
        result.item.code_value  = 11'(item.char_code);
        result.item.code_length = LEN_BYTE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_NUMERIC;
      pending_value <= '0;
      pending_count <= '0;
      pending_bad   <= 1'b0;
    end else if (cfg_valid) begin
      // New mode drops any partial group.
      mode          <= mode_t'(cfg_data);
      pending_value <= '0;
      pending_count <= '0;
      pending_bad   <= 1'b0;
    end else if (fire) begin
      pending_value <= pending_value_next;
      pending_count <= pending_count_next;
      pending_bad   <= pending_bad_next;
    end
  end

endmodule

// ===== design/qsbe_out_stage.sv =====
module qsbe_out_stage import qsbe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  enc_result_t result,
  output logic        advance,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load && result.emit;
    end
  end

  // Hold the payload while the receiver stalls.
  always_ff @(posedge clk) begin
    if (advance && load && result.emit) begin
      out_data <= result.item;
    end
  end

endmodule

// ===== design/qsbe_checker.sv =====
`include "qr_segment_bit_encoder_top_defines.svh"

module qsbe_checker import qsbe_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `QSBE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output transaction changed while stalled")
  `QSBE_ASSERT_NOW(a_len_legal, out_valid, (out_data.code_length == LEN_NUM_ONE) || (out_data.code_length == LEN_ALNUM_ONE) || (out_data.code_length == LEN_NUM_TWO) || (out_data.code_length == LEN_BYTE) || (out_data.code_length == LEN_NUM_THREE) || (out_data.code_length == LEN_ALNUM_TWO), "illegal code length")
  `QSBE_ASSERT_NOW(a_byte_clean, out_valid && (out_data.code_length == LEN_BYTE), !out_data.bad_char, "bad_char set on byte code")
  `QSBE_ASSERT_NOW(a_short_last, out_valid && ((out_data.code_length == LEN_NUM_ONE) || (out_data.code_length == LEN_ALNUM_ONE) || (out_data.code_length == LEN_NUM_TWO)), out_data.last_code, "short group before end of message")
  `QSBE_ASSERT_NOW(a_num_range, out_valid && (out_data.code_length == LEN_NUM_THREE), out_data.code_value < 11'd1000, "three-digit group out of range")

endmodule

bind qr_segment_bit_encoder_top qsbe_checker u_checker (.*);
